// File: design/vrs3d_pkg.sv
package vrs3d_pkg;

    // coordinate span limit and field widths
    localparam int MAX_SPAN  = 63;
    localparam int COORD_W   = 7;
    localparam int MAG_W     = 6;
    localparam int ERR_W     = 9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } state_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture clamped endpoint
        logic init;    // choose driving axis, seed error terms
        logic step;    // advance to next voxel
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;    // current voxel is the endpoint
    } status_t;

endpackage

// File: design/vrs3d_ctrl.sv
module vrs3d_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  vrs3d_pkg::status_t  status,
    output vrs3d_pkg::cmd_t     cmd
);

    vrs3d_pkg::state_t state_reg;
    vrs3d_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vrs3d_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            vrs3d_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = vrs3d_pkg::ST_SETUP;
                end
            end
            vrs3d_pkg::ST_SETUP:
            begin
                cmd.init   = 1'b1;
                state_next = vrs3d_pkg::ST_RUN;
            end
            vrs3d_pkg::ST_RUN:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (status.last)
                    begin
                        state_next = vrs3d_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = vrs3d_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/vrs3d_datapath.sv
module vrs3d_datapath (
    input  logic                                  clk,
    input  vrs3d_pkg::cmd_t                       cmd,
    input  logic signed [vrs3d_pkg::COORD_W-1:0]  end_x,
    input  logic signed [vrs3d_pkg::COORD_W-1:0]  end_y,
    input  logic signed [vrs3d_pkg::COORD_W-1:0]  end_z,
    output logic signed [vrs3d_pkg::COORD_W-1:0]  vox_x,
    output logic signed [vrs3d_pkg::COORD_W-1:0]  vox_y,
    output logic signed [vrs3d_pkg::COORD_W-1:0]  vox_z,
    output logic                                  last_point,
    output vrs3d_pkg::status_t                    status
);

    localparam int CW = vrs3d_pkg::COORD_W;
    localparam int MW = vrs3d_pkg::MAG_W;
    localparam int EW = vrs3d_pkg::ERR_W;

    // per-axis magnitude and sign, captured at load
    logic [MW-1:0]           mag_reg  [3];
    logic [2:0]              neg_reg;
    logic signed [CW-1:0]    pt_reg   [3];
    vrs3d_pkg::axis_t        drv_reg, p_reg, q_reg;
    logic [MW-1:0]           md_reg, mp_reg, mq_reg;
    logic signed [EW-1:0]    errp_reg, errq_reg;
    logic [MW-1:0]           cnt_reg;

    logic signed [CW-1:0]    end_in  [3];
    logic [MW-1:0]           mag_next [3];
    logic [2:0]              neg_next;
    vrs3d_pkg::axis_t        drv_next, p_next, q_next;
    logic [MW-1:0]           md_next, mp_next, mq_next;
    logic signed [EW-1:0]    md2, mp2, mq2;
    logic                    stepp, stepq;
    logic [2:0]              step_en;

    function automatic logic [MW-1:0] pick(input vrs3d_pkg::axis_t a,
                                           input logic [MW-1:0] m0,
                                           input logic [MW-1:0] m1,
                                           input logic [MW-1:0] m2);
        logic [MW-1:0] r;
        r = m0;
        unique case (a)
            vrs3d_pkg::AXIS_X: r = m0;
            vrs3d_pkg::AXIS_Y: r = m1;
            vrs3d_pkg::AXIS_Z: r = m2;
            default:           r = m0;
        endcase
        return r;
    endfunction

    assign end_in[0] = end_x;
    assign end_in[1] = end_y;
    assign end_in[2] = end_z;

    // saturate to the span, then split into sign and magnitude
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            logic signed [CW:0] v;
            logic signed [CW:0] c;
            v = {end_in[j][CW-1], end_in[j]};
            c = v;
            if (v > (CW+1)'(vrs3d_pkg::MAX_SPAN))
            begin
                c = (CW+1)'(vrs3d_pkg::MAX_SPAN);
            end
            else if (v < -(CW+1)'(vrs3d_pkg::MAX_SPAN))
            begin
                c = -(CW+1)'(vrs3d_pkg::MAX_SPAN);
            end
            neg_next[j] = c[CW];
            mag_next[j] = c[CW] ? MW'(-c) : MW'(c);
        end
    end

    // driving axis: largest magnitude, ties to x then y
    always_comb
    begin
        if (mag_reg[0] >= mag_reg[1] && mag_reg[0] >= mag_reg[2])
        begin
            drv_next = vrs3d_pkg::AXIS_X;
            p_next   = vrs3d_pkg::AXIS_Y;
            q_next   = vrs3d_pkg::AXIS_Z;
        end
        else if (mag_reg[1] >= mag_reg[0] && mag_reg[1] >= mag_reg[2])
        begin
            drv_next = vrs3d_pkg::AXIS_Y;
            p_next   = vrs3d_pkg::AXIS_X;
            q_next   = vrs3d_pkg::AXIS_Z;
        end
        else
        begin
            drv_next = vrs3d_pkg::AXIS_Z;
            p_next   = vrs3d_pkg::AXIS_Y;
            q_next   = vrs3d_pkg::AXIS_X;
        end
        md_next = pick(drv_next, mag_reg[0], mag_reg[1], mag_reg[2]);
        mp_next = pick(p_next,   mag_reg[0], mag_reg[1], mag_reg[2]);
        mq_next = pick(q_next,   mag_reg[0], mag_reg[1], mag_reg[2]);
    end

    assign md2   = $signed({{(EW-MW-1){1'b0}}, md_reg, 1'b0});
    assign mp2   = $signed({{(EW-MW-1){1'b0}}, mp_reg, 1'b0});
    assign mq2   = $signed({{(EW-MW-1){1'b0}}, mq_reg, 1'b0});
    assign stepp = (errp_reg > 0);
    assign stepq = (errq_reg > 0);

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            step_en[j] = (drv_reg == vrs3d_pkg::axis_t'(j))
                       || (stepp && p_reg == vrs3d_pkg::axis_t'(j))
                       || (stepq && q_reg == vrs3d_pkg::axis_t'(j));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int j = 0; j < 3; j++)
            begin
                mag_reg[j] <= mag_next[j];
            end
            neg_reg <= neg_next;
        end
        if (cmd.init)
        begin
            drv_reg  <= drv_next;
            p_reg    <= p_next;
            q_reg    <= q_next;
            md_reg   <= md_next;
            mp_reg   <= mp_next;
            mq_reg   <= mq_next;
            errp_reg <= $signed({{(EW-MW-1){1'b0}}, mp_next, 1'b0})
                      - $signed({{(EW-MW){1'b0}}, md_next});
            errq_reg <= $signed({{(EW-MW-1){1'b0}}, mq_next, 1'b0})
                      - $signed({{(EW-MW){1'b0}}, md_next});
            cnt_reg  <= '0;
            for (int j = 0; j < 3; j++)
            begin
                pt_reg[j] <= '0;
            end
        end
        else if (cmd.step)
        begin
            errp_reg <= (stepp ? errp_reg - md2 : errp_reg) + mp2;
            errq_reg <= (stepq ? errq_reg - md2 : errq_reg) + mq2;
            cnt_reg  <= cnt_reg + MW'(1);
            for (int j = 0; j < 3; j++)
            begin
                if (step_en[j])
                begin
                    pt_reg[j] <= neg_reg[j] ? pt_reg[j] - CW'(1) : pt_reg[j] + CW'(1);
                end
            end
        end
    end

    assign status.last = (cnt_reg == md_reg);
    assign vox_x       = pt_reg[0];
    assign vox_y       = pt_reg[1];
    assign vox_z       = pt_reg[2];
    assign last_point  = status.last;

endmodule

// File: design/voxel_ray_stepper_3d_unit.sv
// 3d voxel line stepper: walks the bresenham line from the origin to an endpoint
// input channel: in_valid / in_stall carry one endpoint request (end_x, end_y, end_z),
//   signed 7-bit, saturated to the span before use
// output channel: out_valid / out_stall carry one voxel per transfer (vox_x, vox_y,
//   vox_z), first the origin, last the endpoint, flagged by last_point
// a request is taken only while the block is idle; in_stall is high otherwise
// the endpoint is saturated and captured as the request is taken; the setup state
//   picks the driving axis and seeds both error terms; the run state then offers
//   the origin voxel
// each request yields |major| + 1 voxels from the datapath's single stepping loop,
//   one voxel a cycle unless out_stall is high; no new request until the last voxel
// receiver stall holds the current voxel steady; the walk resumes when it lifts
// reset clears the controller to idle; datapath registers are loaded per request
// no state carries from one request to the next
module voxel_ray_stepper_3d_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [vrs3d_pkg::COORD_W-1:0]  end_x,
    input  logic signed [vrs3d_pkg::COORD_W-1:0]  end_y,
    input  logic signed [vrs3d_pkg::COORD_W-1:0]  end_z,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [vrs3d_pkg::COORD_W-1:0]  vox_x,
    output logic signed [vrs3d_pkg::COORD_W-1:0]  vox_y,
    output logic signed [vrs3d_pkg::COORD_W-1:0]  vox_z,
    output logic                                  last_point
);

    // command and status between sequencer and stepping datapath
    vrs3d_pkg::cmd_t    cmd;
    vrs3d_pkg::status_t status;

    // sequencer: idle, setup, run
    vrs3d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // saturation, axis choice, error terms and voxel position
    vrs3d_datapath u_datapath (
        .clk        (clk),
        .cmd        (cmd),
        .end_x      (end_x),
        .end_y      (end_y),
        .end_z      (end_z),
        .vox_x      (vox_x),
        .vox_y      (vox_y),
        .vox_z      (vox_z),
        .last_point (last_point),
        .status     (status)
    );

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

// one voxel of a line, as the block presents it
typedef struct packed {
    logic signed [vrs3d_pkg::COORD_W-1:0] x;
    logic signed [vrs3d_pkg::COORD_W-1:0] y;
    logic signed [vrs3d_pkg::COORD_W-1:0] z;
    logic                                 last;
} voxel_t;

class VoxelLineScoreboard;
    voxel_t pending_voxels[$];
    int     mismatches;
    int     requests_noted;
    int     voxels_checked;
    int     longest_line;

    function int outstanding();
        return pending_voxels.size();
    endfunction

    // walk the bresenham line from the origin and queue every voxel
    function void note_request(logic signed [vrs3d_pkg::COORD_W-1:0] ex,
                               logic signed [vrs3d_pkg::COORD_W-1:0] ey,
                               logic signed [vrs3d_pkg::COORD_W-1:0] ez);
        int            mag[3];
        int            dir[3];
        int            pos[3];
        int            coord[3];
        int            drv, mi_a, mi_b, err_a, err_b, n;
        vrs3d_pkg::axis_t major_axis;
        voxel_t        v;
        coord[0] = ex;
        coord[1] = ey;
        coord[2] = ez;
        for (int j = 0; j < 3; j++)
        begin
            if (coord[j] > vrs3d_pkg::MAX_SPAN)
                coord[j] = vrs3d_pkg::MAX_SPAN;
            if (coord[j] < -vrs3d_pkg::MAX_SPAN)
                coord[j] = -vrs3d_pkg::MAX_SPAN;
            dir[j] = (coord[j] < 0) ? -1 : 1;
            mag[j] = (coord[j] < 0) ? -coord[j] : coord[j];
            pos[j] = 0;
        end
        // ties favour x, then y
        if (mag[0] >= mag[1] && mag[0] >= mag[2])
            major_axis = vrs3d_pkg::AXIS_X;
        else if (mag[1] >= mag[2])
            major_axis = vrs3d_pkg::AXIS_Y;
        else
            major_axis = vrs3d_pkg::AXIS_Z;
        case (major_axis)
            vrs3d_pkg::AXIS_X: begin drv = 0; mi_a = 1; mi_b = 2; end
            vrs3d_pkg::AXIS_Y: begin drv = 1; mi_a = 0; mi_b = 2; end
            default:           begin drv = 2; mi_a = 1; mi_b = 0; end
        endcase
        err_a = 2 * mag[mi_a] - mag[drv];
        err_b = 2 * mag[mi_b] - mag[drv];
        for (int i = 0; i <= mag[drv]; i++)
        begin
            v.x    = pos[0][vrs3d_pkg::COORD_W-1:0];
            v.y    = pos[1][vrs3d_pkg::COORD_W-1:0];
            v.z    = pos[2][vrs3d_pkg::COORD_W-1:0];
            v.last = (i == mag[drv]);
            pending_voxels.insert(pending_voxels.size(), v);
            if (err_a > 0)
            begin
                pos[mi_a] += dir[mi_a];
                err_a     -= 2 * mag[drv];
            end
            if (err_b > 0)
            begin
                pos[mi_b] += dir[mi_b];
                err_b     -= 2 * mag[drv];
            end
            err_a     += 2 * mag[mi_a];
            err_b     += 2 * mag[mi_b];
            pos[drv]  += dir[drv];
        end
        n = mag[drv] + 1;
        if (n > longest_line)
            longest_line = n;
        requests_noted++;
    endfunction

    function void check_voxel(voxel_t got);
        voxel_t want;
        if (pending_voxels.size() == 0)
        begin
            $error("unexpected voxel (%0d,%0d,%0d) last=%0b",
                   got.x, got.y, got.z, got.last);
            mismatches++;
            return;
        end
        want = pending_voxels.pop_front();
        voxels_checked++;
        if (got.x !== want.x)
        begin
            $error("vox_x: expected %0d, actual %0d", want.x, got.x);
            mismatches++;
        end
        if (got.y !== want.y)
        begin
            $error("vox_y: expected %0d, actual %0d", want.y, got.y);
            mismatches++;
        end
        if (got.z !== want.z)
        begin
            $error("vox_z: expected %0d, actual %0d", want.z, got.z);
            mismatches++;
        end
        if (got.last !== want.last)
        begin
            $error("last_point: expected %0b, actual %0b", want.last, got.last);
            mismatches++;
        end
    endfunction
endclass

module testbench;

    localparam int RANDOM_REQUESTS = 300;
    // worst case: 323 requests x 64 voxels, each slowed by output stalls, plus gaps,
    // taken several times over
    localparam int CYCLE_LIMIT     = 1000000;
    // the block passes its capture and setup states before its first voxel; allow a margin
    localparam int DRAIN_CYCLES    = 10;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic out_stall = 1'b0;
    logic signed [vrs3d_pkg::COORD_W-1:0] end_x = '0;
    logic signed [vrs3d_pkg::COORD_W-1:0] end_y = '0;
    logic signed [vrs3d_pkg::COORD_W-1:0] end_z = '0;

    logic                                 in_stall;
    logic                                 out_valid;
    logic signed [vrs3d_pkg::COORD_W-1:0] vox_x;
    logic signed [vrs3d_pkg::COORD_W-1:0] vox_y;
    logic signed [vrs3d_pkg::COORD_W-1:0] vox_z;
    logic                                 last_point;

    VoxelLineScoreboard line_sb;

    int cycle_count   = 0;
    int burst_left    = 0;
    int stall_hold    = 0;
    int directed_sent = 0;

    voxel_ray_stepper_3d_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .end_x      (end_x),
        .end_y      (end_y),
        .end_z      (end_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .vox_x      (vox_x),
        .vox_y      (vox_y),
        .vox_z      (vox_z),
        .last_point (last_point)
    );

    always #2 clk = ~clk;

    // watchdog: a hung handshake or lost voxel ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d voxels still awaited",
                     cycle_count, line_sb.outstanding());
            $display("Mismatches found");
            $finish;
        end
    end

    // output monitor: a voxel moves when valid is high and we are not stalling
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            line_sb.check_voxel('{vox_x, vox_y, vox_z, last_point});
    end

    // receiver back-pressure: quiet stretches alternate with stretches of
    // random stall runs of random length
    always @(negedge clk)
    begin
        if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
        end
        else if ((cycle_count / 600) % 3 == 0)
        begin
            out_stall <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 30)
        begin
            out_stall  <= 1'b1;
            stall_hold <= $urandom_range(0, 5);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // offer one endpoint request and hold it until the block takes it
    task automatic send_request(input int x, input int y, input int z);
        @(negedge clk);
        in_valid <= 1'b1;
        end_x    <= x[vrs3d_pkg::COORD_W-1:0];
        end_y    <= y[vrs3d_pkg::COORD_W-1:0];
        end_z    <= z[vrs3d_pkg::COORD_W-1:0];
        do
            @(posedge clk);
        while (in_stall);
        line_sb.note_request(x[vrs3d_pkg::COORD_W-1:0], y[vrs3d_pkg::COORD_W-1:0],
                             z[vrs3d_pkg::COORD_W-1:0]);
    endtask

    task automatic idle_sender(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // sender pacing: bursts of random length, random gaps between them
    task automatic pace_sender();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            if ($urandom_range(0, 9) == 0)
                idle_sender($urandom_range(10, 30));
            else
                idle_sender($urandom_range(1, 6));
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // hold off new requests until every queued voxel has come out
    task automatic drain_lines();
        @(negedge clk);
        in_valid <= 1'b0;
        while (line_sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // mostly short lines to keep the run quick, a fair share of long ones,
    // and the full 7-bit range so that -64 saturation turns up too
    function automatic int pick_coord(input int style);
        case (style)
            0:       return $urandom_range(0, 12) - 6;
            1:       return $urandom_range(0, 40) - 20;
            default: return $urandom_range(0, 127) - 64;
        endcase
    endfunction

    task automatic send_directed(input int x, input int y, input int z);
        send_request(x, y, z);
        directed_sent++;
        pace_sender();
    endtask

    initial
    begin
        int style;
        int rx, ry, rz;
        line_sb = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: origin, single-axis extremes, ties, saturation, octants
        send_directed(0, 0, 0);
        send_directed(63, 0, 0);
        send_directed(-63, 0, 0);
        send_directed(0, 63, 0);
        send_directed(0, -63, 0);
        send_directed(0, 0, 63);
        send_directed(0, 0, -63);
        send_directed(-64, 0, 0);
        send_directed(0, -64, 0);
        send_directed(0, 0, -64);
        send_directed(63, 63, 63);
        send_directed(-64, -64, -64);
        send_directed(5, 5, 2);
        send_directed(2, -7, 7);
        send_directed(1, 2, 9);
        send_directed(-3, 10, -4);
        send_directed(1, 1, 1);
        send_directed(-1, 0, 0);
        send_directed(0, 0, 1);
        send_directed(63, -64, 31);
        send_directed(17, -40, 63);
        send_directed(-33, -32, -1);
        send_directed(-42, 21, 42);
        drain_lines();

        // random requests, with a full drain part-way through
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            style = $urandom_range(0, 99);
            if (style < 65)
                style = 0;
            else if (style < 85)
                style = 1;
            else
                style = 2;
            rx = pick_coord(style);
            ry = pick_coord(style);
            rz = pick_coord(style);
            // occasionally flatten an axis or force a tie on magnitude
            case ($urandom_range(0, 19))
                0: rx = 0;
                1: ry = 0;
                2: rz = 0;
                3: ry = ($urandom_range(0, 1) != 0) ? rx : -rx;
                4: rz = ($urandom_range(0, 1) != 0) ? ry : -ry;
                default: ;
            endcase
            send_request(rx, ry, rz);
            if (i == RANDOM_REQUESTS / 2)
                drain_lines();
            else
                pace_sender();
        end

        drain_lines();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d endpoint requests (%0d directed), %0d voxels checked",
                 line_sb.requests_noted, directed_sent, line_sb.voxels_checked);
        $display("longest line %0d voxels, run took %0d cycles",
                 line_sb.longest_line, cycle_count);
        if (line_sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
